/* src/mpbm_pkg.sv */
// Package for the multi-pattern byte matcher: table record types, opcodes,
// sequencer states and sizing constants. No dependencies.
`default_nettype none
package mpbm_pkg;

	localparam int NUM_STATES = 1024;
	localparam int NUM_SLOTS  = 4096;
	localparam int MAX_LEN    = 32;
	localparam int RES_CAP    = 32;
	localparam int ST_W       = $clog2(NUM_STATES);
	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int CNT_W      = $clog2(MAX_LEN) + 1;

	typedef enum logic [2:0] {
		OP_WR_STATE = 3'd0,
		OP_WR_CHILD = 3'd1,
		OP_BYTE     = 3'd2,
		OP_SEG      = 3'd3,
		OP_CTX      = 3'd4
	} opcode_t;

	localparam logic CFG_FOLD = 1'b0;
	localparam logic CFG_ALL  = 1'b1;

	typedef struct packed {
		logic [ST_W-1:0]   fail;
		logic [SLOT_W-1:0] first;
		logic [8:0]        count;
		logic [ST_W-1:0]   olink;
		logic              outp;
		logic [4:0]        dep;
		logic [15:0]       tag;
	} state_rec_t;

	typedef struct packed {
		logic [7:0]      letter;
		logic [ST_W-1:0] target;
	} child_rec_t;

	typedef struct packed {
		logic [ST_W-1:0]    matched_state;
		logic [5:0]         pattern_length;
		logic [31:0]        stream_offset;
		logic signed [31:0] segment_offset;
		logic [15:0]        pattern_tag;
		logic [31:0]        match_total;
		logic               last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_BINIT,
		S_BPROBE,
		S_BCMP,
		S_MISS,
		S_CREAD,
		S_CCHK,
		S_FIN
	} fsm_t;

endpackage
`default_nettype wire

/* src/mpbm_if.sv */
// Channel interfaces of the matcher: input beats and match result beats.
// Standalone; no package needed.
`default_nettype none
interface mpbm_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [11:0] index;
	logic [7:0]  byte_value;
	logic [9:0]  target_state;
	logic [11:0] first_slot;
	logic [8:0]  slot_count;
	logic [9:0]  output_link;
	logic        is_output;
	logic [4:0]  depth;
	logic [15:0] tag_in;

	modport source (output valid, opcode, index, byte_value, target_state, first_slot,
		slot_count, output_link, is_output, depth, tag_in, input ready);
	modport sink (input valid, opcode, index, byte_value, target_state, first_slot,
		slot_count, output_link, is_output, depth, tag_in, output ready);
endinterface

interface mpbm_out_if;
	logic               valid;
	logic               ready;
	logic [9:0]         matched_state;
	logic [5:0]         pattern_length;
	logic [31:0]        stream_offset;
	logic signed [31:0] segment_offset;
	logic [15:0]        pattern_tag;
	logic [31:0]        match_total;
	logic               last;

	modport source (output valid, matched_state, pattern_length, stream_offset,
		segment_offset, pattern_tag, match_total, last, input ready);
	modport sink (input valid, matched_state, pattern_length, stream_offset,
		segment_offset, pattern_tag, match_total, last, output ready);
endinterface
`default_nettype wire

/* src/mpbm_tables.sv */
// State record memory and child slot memory, one write and one registered read each.
// Depends on mpbm_pkg.
`default_nettype none
module mpbm_tables (
	input  wire logic                        clk,
	input  wire logic                        st_we,
	input  wire logic [mpbm_pkg::ST_W-1:0]   st_waddr,
	input  wire mpbm_pkg::state_rec_t        st_wdata,
	input  wire logic [mpbm_pkg::ST_W-1:0]   st_raddr,
	output mpbm_pkg::state_rec_t             st_rdata,
	input  wire logic                        ch_we,
	input  wire logic [mpbm_pkg::SLOT_W-1:0] ch_waddr,
	input  wire mpbm_pkg::child_rec_t        ch_wdata,
	input  wire logic [mpbm_pkg::SLOT_W-1:0] ch_raddr,
	output mpbm_pkg::child_rec_t             ch_rdata
);
	import mpbm_pkg::*;

	state_rec_t state_mem [NUM_STATES];
	child_rec_t child_mem [NUM_SLOTS];

	// state records
	always_ff @(posedge clk) begin
		if (st_we) begin
			state_mem[st_waddr] <= st_wdata;
		end
		st_rdata <= state_mem[st_raddr];
	end

	// child slots
	always_ff @(posedge clk) begin
		if (ch_we) begin
			child_mem[ch_waddr] <= ch_wdata;
		end
		ch_rdata <= child_mem[ch_raddr];
	end
endmodule
`default_nettype wire

/* src/multi_pattern_byte_matcher.sv */
// Top level of the Aho-Corasick byte matcher: sequencer, counters, result register.
// Depends on mpbm_pkg, mpbm_if.sv and mpbm_tables.
//
//   channel  dir  handshake            payload
//   req      in   req.valid/req.ready  opcode, index, byte_value, load fields
//   rsp      out  rsp.valid/rsp.ready  match fields, last
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// Load, segment and context beats are taken in S_IDLE. A byte is accepted in S_IDLE,
// then for each state tried S_LOOK and S_BINIT read its record, and each binary search
// probe (up to 9) passes S_BPROBE and S_BCMP; a miss closes the search in S_BPROBE and
// steps the fail link in S_MISS. Up to 33 states are tried. A hit then passes S_CREAD
// and S_CCHK per output chain entry (the reached state and up to 32 links) and closes
// in S_FIN. These steps follow from the single registered read port of each table.
// arst_n clears control and counters, not the tables. A stalled rsp holds the
// sequencer while a held result must be pushed: before the next one is staged,
// or in S_FIN.
`default_nettype none
module multi_pattern_byte_matcher (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mpbm_in_if.sink    req,
	mpbm_out_if.source rsp,
	input  wire logic  cfg_we,
	input  wire logic  cfg_index,
	input  wire logic  cfg_data
);
	import mpbm_pkg::*;

	fsm_t st_q, st_nx;

	logic              fold_q, all_q, stopped_q;
	logic [ST_W-1:0]   cur_q, s_q, t_q, fail_q;
	logic [31:0]       stream_q, seg_q, total_q;
	logic [CNT_W-1:0]  i_q, j_q, n_q;
	logic [7:0]        letter_q, letter_fold;
	logic [8:0]        lo_q, hi_q, mid_q, mid;
	logic [SLOT_W-1:0] first_q;
	logic [SLOT_W:0]   slot;
	result_t           pend_q, out_q, cand;
	logic              pend_v_q, out_v_q;

	logic              acc, out_free, emit, stall, cont, out_load_mid, out_load_fin;
	logic [CNT_W-1:0]  n_new, i_nx;
	logic [5:0]        len;
	state_rec_t        srd, st_wdata;
	child_rec_t        crd, ch_wdata;
	logic [ST_W-1:0]   saddr;
	logic              st_we, ch_we;

	assign acc = req.valid && req.ready;
	assign req.ready = (st_q == S_IDLE);

	// table writes straight from load beats
	assign st_we = acc && (req.opcode == OP_WR_STATE) && (req.index[11:ST_W] == '0);
	assign ch_we = acc && (req.opcode == OP_WR_CHILD);
	assign st_wdata = '{fail: req.target_state, first: req.first_slot,
		count: req.slot_count, olink: req.output_link, outp: req.is_output,
		dep: req.depth, tag: req.tag_in};
	assign ch_wdata = '{letter: req.byte_value, target: req.target_state};
	assign saddr = (st_q == S_CREAD || st_q == S_CCHK) ? t_q : s_q;

	mpbm_tables u_tables (
		.clk      (clk),
		.st_we    (st_we),
		.st_waddr (req.index[ST_W-1:0]),
		.st_wdata (st_wdata),
		.st_raddr (saddr),
		.st_rdata (srd),
		.ch_we    (ch_we),
		.ch_waddr (req.index[SLOT_W-1:0]),
		.ch_wdata (ch_wdata),
		.ch_raddr (slot[SLOT_W-1:0]),
		.ch_rdata (crd)
	);

	// shared search arithmetic and candidate result
	always_comb begin
		letter_fold = req.byte_value;
		if (fold_q && (req.byte_value inside {[8'h41:8'h5A]})) begin
			letter_fold = req.byte_value + 8'h20;
		end
		mid   = lo_q + ((hi_q - lo_q) >> 1);
		slot  = {1'b0, first_q} + {{(SLOT_W-8){1'b0}}, mid};
		i_nx  = i_q + 1'b1;
		len   = {1'b0, srd.dep} + 6'd1;
		cand  = '{matched_state: t_q, pattern_length: len,
			stream_offset: stream_q - {26'd0, len},
			segment_offset: $signed(seg_q - {26'd0, len}),
			pattern_tag: srd.tag, match_total: total_q + 32'd1, last: 1'b0};
		out_free = !out_v_q || rsp.ready;
		emit  = srd.outp;
		stall = emit && pend_v_q && !out_free;
		n_new = n_q + {{(CNT_W-1){1'b0}}, emit};
		cont  = (j_q < CNT_W'(MAX_LEN)) && (srd.olink != '0)
			&& (n_new < CNT_W'(RES_CAP)) && (all_q || n_new == '0);
	end

	// next state
	always_comb begin
		st_nx = st_q;
		out_load_mid = 1'b0;
		out_load_fin = 1'b0;
		case (st_q)
			S_IDLE: begin
				if (acc && req.opcode == OP_BYTE && !stopped_q) begin
					st_nx = S_LOOK;
				end
			end
			S_LOOK:   st_nx = S_BINIT;
			S_BINIT:  st_nx = S_BPROBE;
			S_BPROBE: begin
				if (lo_q >= hi_q || slot[SLOT_W]) begin
					st_nx = S_MISS;
				end else begin
					st_nx = S_BCMP;
				end
			end
			S_BCMP: begin
				if (crd.letter == letter_q) begin
					st_nx = S_CREAD;
				end else begin
					st_nx = S_BPROBE;
				end
			end
			S_MISS: begin
				if (s_q == '0) begin
					st_nx = S_IDLE;
				end else begin
					st_nx = S_LOOK;
				end
			end
			S_CREAD: st_nx = S_CCHK;
			S_CCHK: begin
				if (!stall) begin
					out_load_mid = emit && pend_v_q;
					st_nx = cont ? S_CREAD : S_FIN;
				end
			end
			S_FIN: begin
				if (!pend_v_q) begin
					st_nx = S_IDLE;
				end else if (out_free) begin
					out_load_fin = 1'b1;
					st_nx = S_IDLE;
				end
			end
			default: st_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b0;
			all_q  <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FOLD) begin
				fold_q <= cfg_data;
			end else begin
				all_q <= cfg_data;
			end
		end
	end

	// context, counters and search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= '0;
			stream_q  <= '0;
			seg_q     <= '0;
			total_q   <= '0;
			stopped_q <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			s_q       <= '0;
			t_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						case (req.opcode)
							OP_SEG: begin
								seg_q     <= '0;
								stopped_q <= 1'b0;
							end
							OP_CTX: begin
								cur_q     <= '0;
								stream_q  <= '0;
								seg_q     <= '0;
								total_q   <= '0;
								stopped_q <= 1'b0;
							end
							OP_BYTE: begin
								if (!stopped_q) begin
									stream_q <= stream_q + 32'd1;
									seg_q    <= seg_q + 32'd1;
									s_q      <= cur_q;
									i_q      <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				S_MISS: begin
					if (s_q == '0) begin
						cur_q <= '0;
					end else begin
						i_q <= i_nx;
						s_q <= (i_nx == CNT_W'(MAX_LEN)) ? '0 : fail_q;
					end
				end
				S_BCMP: begin
					if (crd.letter == letter_q) begin
						cur_q <= crd.target;
						t_q   <= crd.target;
						j_q   <= '0;
						n_q   <= '0;
					end
				end
				S_CCHK: begin
					if (!stall) begin
						if (emit) begin
							pend_v_q <= 1'b1;
							total_q  <= total_q + 32'd1;
						end
						n_q <= n_new;
						j_q <= j_q + 1'b1;
						t_q <= srd.olink;
					end
				end
				S_FIN: begin
					if (out_load_fin) begin
						pend_v_q <= 1'b0;
						if (!all_q) begin
							stopped_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (out_load_mid || out_load_fin) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// search payload registers
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && acc) begin
			letter_q <= letter_fold;
		end
		if (st_q == S_BINIT) begin
			lo_q    <= '0;
			hi_q    <= srd.count;
			fail_q  <= srd.fail;
			first_q <= srd.first;
		end
		if (st_q == S_BPROBE) begin
			mid_q <= mid;
		end
		if (st_q == S_BCMP) begin
			if (crd.letter > letter_q) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + 9'd1;
			end
		end
		if (st_q == S_CCHK && !stall && emit) begin
			pend_q <= cand;
		end
		// last sits in the low bit of the result record
		if (out_load_mid) begin
			out_q <= pend_q;
		end else if (out_load_fin) begin
			out_q <= {pend_q[$bits(result_t)-1:1], 1'b1};
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.matched_state  = out_q.matched_state;
	assign rsp.pattern_length = out_q.pattern_length;
	assign rsp.stream_offset  = out_q.stream_offset;
	assign rsp.segment_offset = out_q.segment_offset;
	assign rsp.pattern_tag    = out_q.pattern_tag;
	assign rsp.match_total    = out_q.match_total;
	assign rsp.last           = out_q.last;

	// no held result while a new beat can be taken
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pend_v_q) else $error("pending result while idle");
	// a stopped segment starts with a final result beat
	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stopped_q) |-> out_v_q && out_q.last) else $error("stop without last beat");
	// every final result is pushed with the running total already counted
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_load_fin |=> out_q.match_total == total_q) else $error("match total mismatch");
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for multi_pattern_byte_matcher: a scoreboard class
// predicts match beats from the table loads and byte beats it sees accepted.
// Depends on mpbm_pkg, mpbm_if.sv and the matcher RTL.
`timescale 1ns / 100ps

import mpbm_pkg::*;

typedef struct {
	logic [2:0]  op;
	logic [11:0] index;
	logic [7:0]  byte_v;
	logic [9:0]  target;
	logic [11:0] first;
	logic [8:0]  count;
	logic [9:0]  olink;
	logic        outp;
	logic [4:0]  dep;
	logic [15:0] tag;
} req_beat_t;

class match_scoreboard;
	state_rec_t  states[NUM_STATES];
	child_rec_t  slots[NUM_SLOTS];
	logic [9:0]  cur;
	logic [31:0] stream_cnt, seg_cnt, total;
	bit          stopped, fold, report_all;
	result_t     pending_matches[$];
	int          errors;

	function void clear_context();
		cur = 0;
		stream_cnt = 0;
		seg_cnt = 0;
		total = 0;
		stopped = 0;
	endfunction

	function void reset_all();
		clear_context();
		fold = 0;
		report_all = 1;
	endfunction

	function void set_reg(logic idx, logic val);
		if (idx == CFG_FOLD) fold = val;
		else report_all = val;
	endfunction

	// binary search over the sorted child slots of one state
	function bit find_child(logic [9:0] st, logic [7:0] letter, output logic [9:0] dst);
		int lo, hi, mid, slot;
		lo = 0;
		hi = states[st].count;
		dst = 0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			slot = states[st].first + mid;
			if (slot >= NUM_SLOTS) return 0;
			if (slots[slot].letter == letter) begin
				dst = slots[slot].target;
				return 1;
			end
			if (slots[slot].letter > letter) hi = mid;
			else lo = mid + 1;
		end
		return 0;
	endfunction

	function void push_match(logic [9:0] st);
		result_t r;
		logic [5:0] len;
		len = {1'b0, states[st].dep} + 6'd1;
		total++;
		r.matched_state = st;
		r.pattern_length = len;
		r.stream_offset = stream_cnt - len;
		r.segment_offset = seg_cnt - len;
		r.pattern_tag = states[st].tag;
		r.match_total = total;
		r.last = 0;
		pending_matches.push_back(r);
	endfunction

	function void note_input(req_beat_t b);
		logic [9:0] s, dst;
		logic [7:0] letter;
		bit hit;
		int n;
		hit = 0;
		n = 0;
		if (b.op == OP_WR_STATE) begin
			if (b.index < NUM_STATES)
				states[b.index] = '{b.target, b.first, b.count, b.olink, b.outp,
					b.dep, b.tag};
			return;
		end
		if (b.op == OP_WR_CHILD) begin
			slots[b.index] = '{b.byte_v, b.target};
			return;
		end
		if (b.op == OP_SEG) begin
			seg_cnt = 0;
			stopped = 0;
			return;
		end
		if (b.op == OP_CTX) begin
			clear_context();
			return;
		end
		if (b.op != OP_BYTE || stopped) return;
		stream_cnt++;
		seg_cnt++;
		letter = b.byte_v;
		if (fold && letter >= 8'h41 && letter <= 8'h5A) letter += 8'h20;
		// walk fail links; after the bound, one last try at the root
		s = cur;
		for (int i = 0; i <= MAX_LEN; i++) begin
			if (i == MAX_LEN) s = 0;
			if (find_child(s, letter, dst)) begin
				hit = 1;
				break;
			end
			if (s == 0) break;
			s = states[s].fail;
		end
		if (!hit) begin
			cur = 0;
			return;
		end
		cur = dst;
		if (states[dst].outp) begin
			push_match(dst);
			n++;
		end
		// output chain, non-output entries skipped
		s = states[dst].olink;
		for (int i = 0; i < MAX_LEN && s != 0 && n < RES_CAP; i++) begin
			if (!report_all && n > 0) break;
			if (states[s].outp) begin
				push_match(s);
				n++;
			end
			s = states[s].olink;
		end
		if (n > 0) begin
			if (!report_all) stopped = 1;
			pending_matches[pending_matches.size() - 1].last = 1;
		end
	endfunction

	function void check_result(result_t got);
		result_t exp;
		if (pending_matches.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected match beat: state %0d tag %h", got.matched_state,
					got.pattern_tag);
			return;
		end
		exp = pending_matches.pop_front();
		if (got.matched_state !== exp.matched_state ||
				got.pattern_length !== exp.pattern_length ||
				got.stream_offset !== exp.stream_offset ||
				got.segment_offset !== exp.segment_offset ||
				got.pattern_tag !== exp.pattern_tag ||
				got.match_total !== exp.match_total || got.last !== exp.last) begin
			errors++;
			if (errors <= 10)
				$display("match mismatch: exp st=%0d len=%0d so=%0d seg=%0d tag=%h tot=%0d last=%0d / got st=%0d len=%0d so=%0d seg=%0d tag=%h tot=%0d last=%0d",
					exp.matched_state, exp.pattern_length, exp.stream_offset,
					exp.segment_offset, exp.pattern_tag, exp.match_total, exp.last,
					got.matched_state, got.pattern_length, got.stream_offset,
					got.segment_offset, got.pattern_tag, got.match_total, got.last);
		end
	endfunction
endclass

module testbench;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 1500;
	localparam int NUM_LIVE = 10;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic cfg_data = 0;
	int   src_idle = 0;
	int   sink_stall = 0;
	int   quiet_cycles = 0;

	logic [7:0] alphabet[8] = '{8'h00, 8'h41, 8'h42, 8'h61, 8'h62, 8'h63, 8'h64, 8'hFF};
	logic [9:0] live_ids[NUM_LIVE] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 1023};

	mpbm_in_if  req();
	mpbm_out_if rsp();

	match_scoreboard sb = new();

	multi_pattern_byte_matcher u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// result sink: random stalls, checks at the rising edge
	always @(negedge clk) rsp.ready <= ($urandom_range(99) >= sink_stall);

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) sb.check_result('{rsp.matched_state,
			rsp.pattern_length, rsp.stream_offset, rsp.segment_offset, rsp.pattern_tag,
			rsp.match_total, rsp.last});
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(req_beat_t b);
		while ($urandom_range(99) < src_idle) begin
			req.valid = 0;
			@(negedge clk);
		end
		req.opcode = b.op;
		req.index = b.index;
		req.byte_value = b.byte_v;
		req.target_state = b.target;
		req.first_slot = b.first;
		req.slot_count = b.count;
		req.output_link = b.olink;
		req.is_output = b.outp;
		req.depth = b.dep;
		req.tag_in = b.tag;
		req.valid = 1;
		do @(posedge clk); while (!req.ready);
		sb.note_input(b);
		@(negedge clk);
	endtask

	task automatic write_state(logic [11:0] idx, logic [9:0] fail, logic [11:0] first,
			logic [8:0] count, logic [9:0] olink, logic outp, logic [4:0] dep,
			logic [15:0] tag);
		req_beat_t b;
		b = '{OP_WR_STATE, idx, $urandom, fail, first, count, olink, outp, dep, tag};
		send_beat(b);
	endtask

	task automatic write_child(logic [11:0] idx, logic [7:0] letter, logic [9:0] target);
		req_beat_t b;
		b = '{OP_WR_CHILD, idx, letter, target, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		send_beat(b);
	endtask

	task automatic send_op(logic [2:0] op, logic [7:0] val);
		req_beat_t b;
		b = '{op, $urandom, val, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		send_beat(b);
	endtask

	// random automaton over the live states, children sorted by letter
	task automatic build_automaton();
		int n;
		logic [11:0] first;
		logic [8:0] count;
		for (int i = 0; i < NUM_LIVE; i++) begin
			first = 16 * i;
			n = 0;
			for (int k = 0; k < 8; k++) begin
				if ($urandom_range(1)) begin
					write_child(first + n, alphabet[k], live_ids[$urandom_range(NUM_LIVE - 1)]);
					n++;
				end
			end
			count = n;
			// now and then a wide range whose first probe runs off the slot table
			if ($urandom_range(15) == 0) begin
				first = $urandom_range(3968, 4095);
				count = 256;
			end
			write_state(live_ids[i],
				$urandom_range(2) ? live_ids[$urandom_range(NUM_LIVE - 1)] : 10'd0,
				first, count,
				$urandom_range(1) ? live_ids[$urandom_range(NUM_LIVE - 1)] : 10'd0,
				$urandom_range(1), $urandom, $urandom);
		end
	endtask

	// random traffic; writes keep every reachable state and slot loaded
	task automatic random_item();
		int pick;
		logic [7:0] letter;
		pick = $urandom_range(99);
		letter = alphabet[$urandom_range(7)];
		if (pick < 60) send_op(OP_BYTE, letter);
		else if (pick < 72) send_op(OP_BYTE, $urandom_range(1) ? letter & 8'hDF : letter);
		else if (pick < 78) send_op(OP_BYTE, $urandom);
		else if (pick < 83) send_op(OP_SEG, $urandom);
		else if (pick < 86) send_op(OP_CTX, $urandom);
		else if (pick < 89) send_op($urandom_range(5, 7), $urandom);
		else if (pick < 94) write_child($urandom, $urandom,
			live_ids[$urandom_range(NUM_LIVE - 1)]);
		else write_state($urandom_range(1) ? $urandom_range(9, 1022) :
			$urandom_range(1024, 4095), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// config writes only once the block has drained
	task automatic set_regs(logic fold_v, logic all_v);
		req.valid = 0;
		while (sb.pending_matches.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1;
		cfg_index = CFG_FOLD;
		cfg_data = fold_v;
		@(negedge clk);
		cfg_index = CFG_ALL;
		cfg_data = all_v;
		@(negedge clk);
		cfg_we = 0;
		sb.set_reg(CFG_FOLD, fold_v);
		sb.set_reg(CFG_ALL, all_v);
	endtask

	initial begin
		req.valid = 0;
		req.opcode = OP_CTX;
		req.index = 0;
		req.byte_value = 0;
		req.target_state = 0;
		req.first_slot = 0;
		req.slot_count = 0;
		req.output_link = 0;
		req.is_output = 0;
		req.depth = 0;
		req.tag_in = 0;
		rsp.ready = 1;
		sb.reset_all();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: cyclic output chain hits the result cap
		write_child(100, 8'h78, 7);
		write_state(0, 0, 100, 1, 0, 0, 0, 16'h0000);
		write_state(7, 0, 0, 0, 8, 1, 5'd31, 16'hFFFF);
		write_state(8, 7, 0, 0, 7, 1, 5'd0, 16'hA5A5);
		send_op(OP_BYTE, 8'h78);
		// cyclic fail links away from the root hit the fail bound
		write_state(9, 10, 0, 0, 0, 0, 0, 0);
		write_state(10, 9, 0, 0, 0, 0, 0, 0);
		write_child(101, 8'h79, 9);
		write_state(0, 0, 100, 2, 0, 0, 0, 0);
		send_op(OP_BYTE, 8'h79);
		send_op(OP_BYTE, 8'h78);
		// wide range beyond the slot table, byte extremes, ignored writes and opcodes
		write_state(1023, 0, 4095, 256, 0, 1, 5'd31, 16'hFFFF);
		write_child(102, 8'hFF, 1023);
		write_state(0, 0, 100, 3, 0, 0, 0, 0);
		send_op(OP_BYTE, 8'hFF);
		send_op(OP_BYTE, 8'h00);
		write_state(4095, 10'h3FF, 12'hFFF, 9'h1FF, 10'h3FF, 1, 5'h1F, 16'hFFFF);
		send_op(3'd5, 8'h78);
		send_op(3'd6, 8'h78);
		send_op(3'd7, 8'h78);
		send_op(OP_SEG, 0);
		send_op(OP_BYTE, 8'h78);
		send_op(OP_CTX, 0);
		send_op(OP_BYTE, 8'h58);

		// random phases: idling pattern and register setting change per phase
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_regs(1, 1);
				1: set_regs(1, 0);
				2: set_regs(0, 0);
				default: set_regs(0, 1);
			endcase
			src_idle = (p == 1 || p == 3) ? 73 : 0;
			sink_stall = (p == 2 || p == 3) ? 73 : 0;
			if (p == 3) begin
				src_idle = 31;
				sink_stall = 31;
			end
			build_automaton();
			for (int i = 0; i < 24; i++) begin
				random_item();
			end
		end

		req.valid = 0;
		while (sb.pending_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
